### rtl/safd_pkg.sv
package safd_pkg;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_ADDR = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_SYNC = 2'd0,
		REG_ADDR = 2'd1,
		REG_END  = 2'd2
	} reg_idx_t;

	localparam int unsigned PADDR_W     = 4;
	localparam int unsigned PDATA_W     = 32;
	localparam logic [2:0]  FIELD_TOTAL = 3'd5;

	localparam logic [7:0] SYNC_RESET = 8'hAA;
	localparam logic [7:0] ADDR_RESET = 8'hBB;
	localparam logic [7:0] END_RESET  = 8'h7F;

	typedef logic [3:0] nibble_t;

endpackage

### rtl/safd_if.sv
interface safd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface safd_entry_if;
	logic        valid;
	logic        ready;
	logic [3:0]  entry_row;
	logic [7:0]  entry_column;
	logic [15:0] entry_word;
	logic        ended_by_marker;

	modport source (output valid, output entry_row, output entry_column,
		output entry_word, output ended_by_marker, input ready);
	modport sink   (input valid, input entry_row, input entry_column,
		input entry_word, input ended_by_marker, output ready);
endinterface

### rtl/sync_address_frame_deframer.sv
// Byte-stream deframer: hunts for the sync byte, checks the address byte, then
// collects a column byte and four low nibbles, and emits one entry when the end
// byte arrives or when any byte follows the fifth field. One byte is taken per
// clock cycle; each byte passes an input register and updates the frame-state
// registers, and the byte that closes a frame loads its entry into an output
// register. A pending entry stalls intake only when a further entry is due
// before it has been taken. Sync, address and end bytes are set through the
// APB port at byte addresses 0, 4 and 8.
module sync_address_frame_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	safd_byte_if.sink                         rx,
	safd_entry_if.source                      entry,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [safd_pkg::PADDR_W-1:0]      paddr,
	input  logic [safd_pkg::PDATA_W-1:0]      pwdata,
	output logic [safd_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);

	logic [7:0] sync_q, addr_q, end_q;

	logic       v_s1;
	logic [7:0] byte_s1;

	safd_pkg::phase_t  phase_q, phase_d;
	logic [2:0]        count_q, count_d;
	logic [7:0]        column_q, column_d;
	safd_pkg::nibble_t nib_q [4];
	safd_pkg::nibble_t nib_d [4];

	logic        out_valid_q;
	logic [3:0]  row_q;
	logic [7:0]  col_out_q;
	logic [15:0] word_q;
	logic        marker_q;

	logic hit_end, emit, consume, out_free;
	logic [1:0] nib_idx;
	safd_pkg::reg_idx_t widx;

	assign widx   = safd_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		case (widx)
			safd_pkg::REG_SYNC: prdata[7:0] = sync_q;
			safd_pkg::REG_ADDR: prdata[7:0] = addr_q;
			safd_pkg::REG_END:  prdata[7:0] = end_q;
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= safd_pkg::SYNC_RESET;
			addr_q <= safd_pkg::ADDR_RESET;
			end_q  <= safd_pkg::END_RESET;
		end else if (psel && penable && pwrite) begin
			case (widx)
				safd_pkg::REG_SYNC: sync_q <= pwdata[7:0];
				safd_pkg::REG_ADDR: addr_q <= pwdata[7:0];
				safd_pkg::REG_END:  end_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign hit_end  = (byte_s1 == end_q);
	assign emit     = v_s1 && (phase_q == safd_pkg::PH_DATA)
		&& (hit_end || (count_q == safd_pkg::FIELD_TOTAL));
	assign out_free = !out_valid_q || entry.ready;
	assign consume  = v_s1 && (!emit || out_free);
	assign rx.ready = !v_s1 || consume;
	assign nib_idx  = 2'(count_q - 3'd1);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		column_d = column_q;
		for (int i = 0; i < 4; i++) begin
			nib_d[i] = nib_q[i];
		end
		case (phase_q)
			safd_pkg::PH_ADDR: begin
				phase_d = (byte_s1 == addr_q) ? safd_pkg::PH_DATA : safd_pkg::PH_HUNT;
			end
			safd_pkg::PH_DATA: begin
				if (emit) begin
					phase_d  = safd_pkg::PH_HUNT;
					count_d  = '0;
					column_d = '0;
					for (int i = 0; i < 4; i++) begin
						nib_d[i] = '0;
					end
				end else begin
					if (count_q == '0) begin
						column_d = byte_s1;
					end else begin
						nib_d[nib_idx] = byte_s1[3:0];
					end
					count_d = count_q + 3'd1;
				end
			end
			default: begin
				phase_d = (byte_s1 == sync_q) ? safd_pkg::PH_ADDR : safd_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= safd_pkg::PH_HUNT;
			count_q  <= '0;
			column_q <= '0;
			for (int i = 0; i < 4; i++) begin
				nib_q[i] <= '0;
			end
		end else if (consume) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			column_q <= column_d;
			for (int i = 0; i < 4; i++) begin
				nib_q[i] <= nib_d[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			row_q     <= nib_q[0];
			col_out_q <= column_q;
			word_q    <= {nib_q[3], nib_q[2], nib_q[1], nib_q[0]};
			marker_q  <= hit_end;
		end
	end

	assign entry.valid           = out_valid_q;
	assign entry.entry_row       = row_q;
	assign entry.entry_column    = col_out_q;
	assign entry.entry_word      = word_q;
	assign entry.ended_by_marker = marker_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= safd_pkg::FIELD_TOTAL)
		else $error("field count beyond five");

	a_count_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (phase_q == safd_pkg::PH_DATA))
		else $error("fields held outside data phase");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && consume) |=> (phase_q == safd_pkg::PH_HUNT && count_q == '0))
		else $error("frame not cleared after entry");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && consume) |=> (out_valid_q && entry.entry_row == entry.entry_word[3:0]))
		else $error("entry not loaded into output register");

	a_no_marker_full: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !hit_end) |-> (count_q == safd_pkg::FIELD_TOTAL))
		else $error("unmarked close before five fields");

endmodule

### test/tb_sync_address_frame_deframer.sv
module tb_sync_address_frame_deframer;

	typedef struct packed {
		logic [3:0]  row;
		logic [7:0]  column;
		logic [15:0] word;
		logic        marker;
	} entry_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       typed;
		logic       has_entry;
		entry_t     result;
	} stim_row_t;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int ENTRY_LATENCY = 6;
	localparam int RUN_LIMIT = 2_000_000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [safd_pkg::PADDR_W-1:0]  paddr;
	logic [safd_pkg::PDATA_W-1:0]  pwdata;
	logic [safd_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	safd_byte_if  rx_if();
	safd_entry_if entry_if();

	sync_address_frame_deframer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.entry   (entry_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// predictor state and register copy
	logic [7:0]        cfg_sync;
	logic [7:0]        cfg_addr;
	logic [7:0]        cfg_end;
	safd_pkg::phase_t  frame_phase;
	logic [2:0]        fields_held;
	logic [7:0]        column_hold;
	safd_pkg::nibble_t nibbles [4];

	entry_t     expected_entries[$];
	stim_row_t  directed_rows[$];

	int  error_count;
	int  accepted_bytes;
	int  entries_seen;
	int  marker_closes;
	int  settings_applied;
	int  burst_left;
	bit  calm;

	logic [15:0] stall_pattern;
	int          stall_age;

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output entry_t e);
		e = '0;
		case (frame_phase)
		safd_pkg::PH_ADDR: begin
			frame_phase = (b == cfg_addr) ? safd_pkg::PH_DATA : safd_pkg::PH_HUNT;
			return 1'b0;
		end
		safd_pkg::PH_DATA: begin
			if (b == cfg_end || fields_held == safd_pkg::FIELD_TOTAL) begin
				e.row = nibbles[0];
				e.column = column_hold;
				e.word = {nibbles[3], nibbles[2], nibbles[1], nibbles[0]};
				e.marker = (b == cfg_end);
				fields_held = '0;
				column_hold = '0;
				foreach (nibbles[i]) nibbles[i] = '0;
				frame_phase = safd_pkg::PH_HUNT;
				return 1'b1;
			end
			if (fields_held == 3'd0)
				column_hold = b;
			else
				nibbles[2'(fields_held - 3'd1)] = b[3:0];
			fields_held = fields_held + 3'd1;
			return 1'b0;
		end
		default: begin
			frame_phase = (b == cfg_sync) ? safd_pkg::PH_ADDR : safd_pkg::PH_HUNT;
			return 1'b0;
		end
		endcase
	endfunction

	function automatic stim_row_t frame_row(input logic [7:0] b, input logic typed,
			input logic has, input logic [3:0] r, input logic [7:0] c,
			input logic [15:0] w, input logic m);
		stim_row_t s;
		s.rx_byte = b;
		s.typed = typed;
		s.has_entry = has;
		s.result.row = r;
		s.result.column = c;
		s.result.word = w;
		s.result.marker = m;
		return s;
	endfunction

	// receiver: stall on a rotating pattern, reloaded now and then
	always @(posedge clk) begin
		stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
		stall_age++;
		if (stall_age >= 64) begin
			stall_age = 0;
			stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
				: (16'($urandom) | 16'h0001);
		end
		entry_if.ready <= calm ? 1'b1 : stall_pattern[0];
	end

	always @(posedge clk) begin
		entry_t want;
		if (arst_n && entry_if.valid && entry_if.ready) begin
			if (expected_entries.size() == 0) begin
				$display("%0t: unexpected entry, got row %0h column %0h word %0h marker %0b",
					$time, entry_if.entry_row, entry_if.entry_column, entry_if.entry_word,
					entry_if.ended_by_marker);
				error_count++;
			end else begin
				want = expected_entries.pop_front();
				check_field("entry_row", 32'(want.row), 32'(entry_if.entry_row));
				check_field("entry_column", 32'(want.column), 32'(entry_if.entry_column));
				check_field("entry_word", 32'(want.word), 32'(entry_if.entry_word));
				check_field("ended_by_marker", 32'(want.marker),
					32'(entry_if.ended_by_marker));
				entries_seen++;
				if (want.marker)
					marker_closes++;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic typed, input logic typed_has,
			input entry_t typed_entry);
		entry_t got;
		bit     has;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!calm && $urandom_range(0, 2) != 0) begin
				rx_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		accepted_bytes++;
		has = deframe_byte(b, got);
		if (typed) begin
			has = typed_has;
			got = typed_entry;
		end
		if (has)
			expected_entries.push_back(got);
	endtask

	task automatic flush_entries();
		rx_if.valid <= 1'b0;
		burst_left = 0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (ENTRY_LATENCY) @(posedge clk);
	endtask

	// write, then read back over the same address
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
		safd_pkg::REG_SYNC: cfg_sync = value;
		safd_pkg::REG_ADDR: cfg_addr = value;
		safd_pkg::REG_END:  cfg_end = value;
		default: ;
		endcase
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx != REG_SPARE)
			check_field("register readback", {24'h0, value}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	task automatic send_frame_mix();
		logic [7:0] frame[$];
		int pick;
		int n;
		pick = $urandom_range(0, 9);
		if (pick <= 6) begin
			frame.push_back(cfg_sync);
			frame.push_back(cfg_addr);
			frame.push_back(8'($urandom));
			n = $urandom_range(0, 4);
			repeat (n) frame.push_back(8'($urandom));
			if (n < 4 || $urandom_range(0, 1) == 0)
				frame.push_back(cfg_end);
			else
				frame.push_back(8'($urandom));
		end else if (pick == 7) begin
			repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
		end else if (pick == 8) begin
			frame.push_back(cfg_sync);
			frame.push_back(cfg_addr ^ (8'h01 << $urandom_range(0, 7)));
		end else begin
			frame.push_back(cfg_sync);
			frame.push_back(cfg_addr);
			frame.push_back(8'($urandom));
			frame.push_back(cfg_end);
		end
		foreach (frame[i]) send_byte(frame[i], 1'b0, 1'b0, '0);
	endtask

	task automatic run_random(input int budget);
		int target;
		target = accepted_bytes + budget;
		while (accepted_bytes < target) begin
			send_frame_mix();
			if ($urandom_range(0, 40) == 0)
				flush_entries();
		end
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [7:0] s;
		logic [7:0] a;
		logic [7:0] e;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		entry_if.ready = 1'b0;
		stall_pattern = 16'hF0F3;
		stall_age = 0;
		calm = 1'b0;
		burst_left = 0;
		error_count = 0;
		accepted_bytes = 0;
		entries_seen = 0;
		marker_closes = 0;
		settings_applied = 0;
		cfg_sync = safd_pkg::SYNC_RESET;
		cfg_addr = safd_pkg::ADDR_RESET;
		cfg_end = safd_pkg::END_RESET;
		frame_phase = safd_pkg::PH_HUNT;
		fields_held = '0;
		column_hold = '0;
		foreach (nibbles[i]) nibbles[i] = '0;

		// full frame closed by a sync-valued byte, which is consumed
		directed_rows.push_back(frame_row(safd_pkg::SYNC_RESET, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::ADDR_RESET, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'h01, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'h02, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'h03, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'h04, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'h05, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::SYNC_RESET, 1, 1, 4'h2, 8'h01,
			16'h5432, 1'b0));
		directed_rows.push_back(frame_row(safd_pkg::ADDR_RESET, 1, 0, 0, 0, 0, 0));
		// end byte right after the address
		directed_rows.push_back(frame_row(safd_pkg::SYNC_RESET, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::ADDR_RESET, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::END_RESET, 1, 1, 4'h0, 8'h00,
			16'h0000, 1'b1));
		// wrong address byte is dropped without a sync check
		directed_rows.push_back(frame_row(safd_pkg::SYNC_RESET, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::SYNC_RESET, 1, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::ADDR_RESET, 1, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::END_RESET, 1, 0, 0, 0, 0, 0));
		// extreme bytes, end byte after all five fields
		directed_rows.push_back(frame_row(safd_pkg::SYNC_RESET, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::ADDR_RESET, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'hFF, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'hFF, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'hF0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'h0F, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(8'h00, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(frame_row(safd_pkg::END_RESET, 1, 1, 4'hF, 8'hFF,
			16'h0F0F, 1'b1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
				directed_rows[i].has_entry, directed_rows[i].result);
		run_random(200);
		flush_entries();

		for (int p = 0; p < 6; p++) begin
			case (p)
			0: begin s = 8'h00; a = 8'hFF; e = 8'h00; end
			1: begin s = 8'hFF; a = 8'h00; e = 8'hFF; end
			2: begin s = 8'h5A; a = 8'h5A; e = 8'h5A; end
			default: begin s = 8'($urandom); a = 8'($urandom); e = 8'($urandom); end
			endcase
			calm = (p == 4);
			write_reg(safd_pkg::REG_SYNC, s);
			write_reg(safd_pkg::REG_ADDR, a);
			write_reg(safd_pkg::REG_END, e);
			if (p == 3)
				write_reg(REG_SPARE, 8'($urandom));
			run_random(215);
			flush_entries();
		end

		$display("%0d bytes sent through %0d register writes, %0d entries checked",
			accepted_bytes, settings_applied, entries_seen);
		$display("%0d entries closed by the end byte, %0d after the fifth field",
			marker_closes, entries_seen - marker_closes);
		if (error_count == 0 && expected_entries.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
